### src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, prop, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/ddo_pkg.sv
// ---------------------------------------------------------------------------
// ddo_pkg
// Shared widths, command codes, state type and helpers for the odometry block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ddo_pkg;

  // Field widths
  localparam int COUNT_W   = 32;
  localparam int POS_W     = 48;
  localparam int HEAD_W    = 32;
  localparam int RATE_W    = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int IV_W      = 24;

  // Internal arithmetic widths
  localparam int SUM_W     = COUNT_W + 1;          // S and T
  localparam int PROD_W    = SUM_W + CFG_W;        // S*mpc, T*tpc
  localparam int TRAVEL_SH = 9;
  localparam int TRAVEL_W  = PROD_W - TRAVEL_SH;   // mean travel, Q.24
  localparam int CORD_W    = 34;
  localparam int CORD_STEPS = 30;
  localparam int CORD_FRAC = 30;
  localparam int XY_W      = TRAVEL_W + CORD_W;
  localparam int STEP_W    = XY_W - CORD_FRAC;
  localparam int POSSUM_W  = STEP_W + 1;
  localparam int SCALE_W   = 20;
  localparam int NUM_W     = PROD_W + SCALE_W;
  localparam int DEN_W     = 64;
  localparam int QUO_W     = 32;
  localparam int CNT_W     = 6;
  localparam int BIT_IDX_W = 5;

  localparam int MUL1_LAST = CFG_W - 1;
  localparam int MUL2_LAST = CORD_W - 1;
  localparam int DIV_LAST  = QUO_W - 1;

  localparam logic [SCALE_W-1:0] RATE_SCALE = 20'd1000000;  // us per s
  localparam logic signed [CORD_W-1:0] CORD_GAIN = 34'sd652032874;
  localparam logic [CFG_W-1:0] MPC_RESET = 32'd112441980;
  localparam logic [CFG_W-1:0] TPC_RESET = 32'd33140180;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_METRES_PER_COUNT,
    REG_TURN_PER_COUNT_DIFF
  } reg_idx_t;

  // Datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL1,
    OP_LD2,
    OP_MUL2,
    OP_PREP,
    OP_CHK,
    OP_DIV,
    OP_COMMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [CNT_W-1:0] idx;
  } cmd_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_LD2,
    ST_MUL2,
    ST_PREP,
    ST_CHK,
    ST_DIV,
    ST_DONE
  } st_t;

  // CORDIC arctangent table, binary angle
  function automatic logic [HEAD_W-1:0] atan_at(input logic [BIT_IDX_W-1:0] i);
    logic [HEAD_W-1:0] a;
    case (i)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Bit of the rate scale constant, zero above its width
  function automatic logic scale_bit(input logic [CNT_W-1:0] i);
    logic b;
    if (i < CNT_W'(SCALE_W)) b = RATE_SCALE[i[BIT_IDX_W-1:0]];
    else b = 1'b0;
    return b;
  endfunction

  // Clamp a wide position sum to the pose width
  function automatic logic [POS_W-1:0] pos_sat(input logic [POSSUM_W-1:0] v);
    logic [POS_W-1:0] r;
    if ((&v[POSSUM_W-1:POS_W-1]) || !(|v[POSSUM_W-1:POS_W-1])) r = v[POS_W-1:0];
    else if (v[POSSUM_W-1]) r = {1'b1, {(POS_W-1){1'b0}}};
    else r = {1'b0, {(POS_W-1){1'b1}}};
    return r;
  endfunction

  // Rate result from sign, quotient magnitude and overflow
  function automatic logic [RATE_W-1:0] rate_out(input logic iv_zero, input logic ovf,
                                                 input logic neg,
                                                 input logic [QUO_W-1:0] q);
    logic [RATE_W-1:0] r;
    if (iv_zero) r = '0;
    else if (ovf) r = neg ? {1'b1, {(RATE_W-1){1'b0}}} : {1'b0, {(RATE_W-1){1'b1}}};
    else r = neg ? (~q + 1'b1) : q;
    return r;
  endfunction

endpackage

### src/ddo_ctrl.sv
// ---------------------------------------------------------------------------
// ddo_ctrl
// Sequencer: steps the datapath through multiply, CORDIC, divide and commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_ctrl import ddo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd
);

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // State, step counter and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    cmd.op        = OP_NONE;
    cmd.idx       = cnt_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.op = OP_MUL1;
        if (cnt_r == CNT_W'(MUL1_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LD2;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LD2: begin
        cmd.op    = OP_LD2;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.op = OP_MUL2;
        if (cnt_r == CNT_W'(MUL2_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_PREP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.op    = OP_CHK;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_LAST)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        // wait for the result slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### src/ddo_datapath.sv
// ---------------------------------------------------------------------------
// ddo_datapath
// Pose state, serial multipliers, CORDIC rotator and rate dividers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ddo_datapath import ddo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  input  logic [COUNT_W-1:0]         in_left_count,
  input  logic [COUNT_W-1:0]         in_right_count,
  input  logic [IV_W-1:0]            in_interval_us,
  input  cmd_t                       cmd,
  output logic signed [POS_W-1:0]    out_pos_x,
  output logic signed [POS_W-1:0]    out_pos_y,
  output logic [HEAD_W-1:0]          out_heading,
  output logic signed [RATE_W-1:0]   out_linear_rate,
  output logic signed [RATE_W-1:0]   out_turn_rate
);

  // Control state (reset)
  logic [CFG_W-1:0]   mpc_r, mpc_nxt, tpc_r, tpc_nxt;
  logic [COUNT_W-1:0] prev_l_r, prev_l_nxt, prev_r_r, prev_r_nxt;
  logic               first_r, first_nxt;
  logic [POS_W-1:0]   pose_x_r, pose_x_nxt, pose_y_r, pose_y_nxt;
  logic [HEAD_W-1:0]  pose_h_r, pose_h_nxt;

  // Work registers
  logic [IV_W-1:0]          iv_r, iv_nxt;
  logic [PROD_W-1:0]        mcs_r, mcs_nxt, mct_r, mct_nxt;
  logic [PROD_W-1:0]        acc_p_r, acc_p_nxt, acc_h_r, acc_h_nxt;
  logic signed [CORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt, cz_r, cz_nxt;
  logic                     flip_r, flip_nxt;
  logic [XY_W-1:0]          mcd_r, mcd_nxt, acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic signed [CORD_W-1:0] cm_r, cm_nxt, sm_r, sm_nxt;
  logic [NUM_W-1:0]         mcp_r, mcp_nxt, mch_r, mch_nxt;
  logic [NUM_W-1:0]         acc_nl_r, acc_nl_nxt, acc_nt_r, acc_nt_nxt;
  logic [NUM_W-1:0]         mag_l_r, mag_l_nxt, mag_t_r, mag_t_nxt;
  logic                     neg_l_r, neg_l_nxt, neg_t_r, neg_t_nxt;
  logic                     ovf_l_r, ovf_l_nxt, ovf_t_r, ovf_t_nxt;
  logic [DEN_W-1:0]         dsh_l_r, dsh_l_nxt, dsh_t_r, dsh_t_nxt;
  logic [DEN_W-1:0]         rem_l_r, rem_l_nxt, rem_t_r, rem_t_nxt;
  logic [QUO_W-1:0]         q_l_r, q_l_nxt, q_t_r, q_t_nxt;
  logic [RATE_W-1:0]        lin_r, lin_nxt, trn_r, trn_nxt;

  // Combinational helpers
  logic [COUNT_W-1:0]       dl, dr;
  logic [SUM_W-1:0]         s_sum, t_dif;
  logic [HEAD_W-1:0]        h_fold;
  logic signed [CORD_W-1:0] xs, ys, at;
  logic                     last2;
  logic [POSSUM_W-1:0]      sum_x, sum_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mpc_r    <= MPC_RESET;
      tpc_r    <= TPC_RESET;
      prev_l_r <= '0;
      prev_r_r <= '0;
      first_r  <= 1'b1;
      pose_x_r <= '0;
      pose_y_r <= '0;
      pose_h_r <= '0;
    end else begin
      mpc_r    <= mpc_nxt;
      tpc_r    <= tpc_nxt;
      prev_l_r <= prev_l_nxt;
      prev_r_r <= prev_r_nxt;
      first_r  <= first_nxt;
      pose_x_r <= pose_x_nxt;
      pose_y_r <= pose_y_nxt;
      pose_h_r <= pose_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iv_r     <= iv_nxt;
    mcs_r    <= mcs_nxt;
    mct_r    <= mct_nxt;
    acc_p_r  <= acc_p_nxt;
    acc_h_r  <= acc_h_nxt;
    cx_r     <= cx_nxt;
    cy_r     <= cy_nxt;
    cz_r     <= cz_nxt;
    flip_r   <= flip_nxt;
    mcd_r    <= mcd_nxt;
    acc_x_r  <= acc_x_nxt;
    acc_y_r  <= acc_y_nxt;
    cm_r     <= cm_nxt;
    sm_r     <= sm_nxt;
    mcp_r    <= mcp_nxt;
    mch_r    <= mch_nxt;
    acc_nl_r <= acc_nl_nxt;
    acc_nt_r <= acc_nt_nxt;
    mag_l_r  <= mag_l_nxt;
    mag_t_r  <= mag_t_nxt;
    neg_l_r  <= neg_l_nxt;
    neg_t_r  <= neg_t_nxt;
    ovf_l_r  <= ovf_l_nxt;
    ovf_t_r  <= ovf_t_nxt;
    dsh_l_r  <= dsh_l_nxt;
    dsh_t_r  <= dsh_t_nxt;
    rem_l_r  <= rem_l_nxt;
    rem_t_r  <= rem_t_nxt;
    q_l_r    <= q_l_nxt;
    q_t_r    <= q_t_nxt;
    lin_r    <= lin_nxt;
    trn_r    <= trn_nxt;
  end

  // Count deltas; the first request only sets the reference counts
  always_comb begin
    dl     = first_r ? '0 : (in_left_count - prev_l_r);
    dr     = first_r ? '0 : (in_right_count - prev_r_r);
    s_sum  = {dl[COUNT_W-1], dl} + {dr[COUNT_W-1], dr};
    t_dif  = {dr[COUNT_W-1], dr} - {dl[COUNT_W-1], dl};
    // fold the heading into the right half plane
    h_fold = pose_h_r ^ {pose_h_r[HEAD_W-1] ^ pose_h_r[HEAD_W-2], {(HEAD_W-1){1'b0}}};
    xs     = cx_r >>> cmd.idx[BIT_IDX_W-1:0];
    ys     = cy_r >>> cmd.idx[BIT_IDX_W-1:0];
    at     = signed'(CORD_W'(atan_at(cmd.idx[BIT_IDX_W-1:0])));
    last2  = (cmd.idx == CNT_W'(MUL2_LAST));
    sum_x  = {{(POSSUM_W-POS_W){pose_x_r[POS_W-1]}}, pose_x_r}
           + {acc_x_r[XY_W-1], acc_x_r[XY_W-1:CORD_FRAC]};
    sum_y  = {{(POSSUM_W-POS_W){pose_y_r[POS_W-1]}}, pose_y_r}
           + {acc_y_r[XY_W-1], acc_y_r[XY_W-1:CORD_FRAC]};
  end

  // Next-value logic per operation
  always_comb begin
    mpc_nxt    = mpc_r;
    tpc_nxt    = tpc_r;
    prev_l_nxt = prev_l_r;
    prev_r_nxt = prev_r_r;
    first_nxt  = first_r;
    pose_x_nxt = pose_x_r;
    pose_y_nxt = pose_y_r;
    pose_h_nxt = pose_h_r;
    iv_nxt     = iv_r;
    mcs_nxt    = mcs_r;
    mct_nxt    = mct_r;
    acc_p_nxt  = acc_p_r;
    acc_h_nxt  = acc_h_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    cz_nxt     = cz_r;
    flip_nxt   = flip_r;
    mcd_nxt    = mcd_r;
    acc_x_nxt  = acc_x_r;
    acc_y_nxt  = acc_y_r;
    cm_nxt     = cm_r;
    sm_nxt     = sm_r;
    mcp_nxt    = mcp_r;
    mch_nxt    = mch_r;
    acc_nl_nxt = acc_nl_r;
    acc_nt_nxt = acc_nt_r;
    mag_l_nxt  = mag_l_r;
    mag_t_nxt  = mag_t_r;
    neg_l_nxt  = neg_l_r;
    neg_t_nxt  = neg_t_r;
    ovf_l_nxt  = ovf_l_r;
    ovf_t_nxt  = ovf_t_r;
    dsh_l_nxt  = dsh_l_r;
    dsh_t_nxt  = dsh_t_r;
    rem_l_nxt  = rem_l_r;
    rem_t_nxt  = rem_t_r;
    q_l_nxt    = q_l_r;
    q_t_nxt    = q_t_r;
    lin_nxt    = lin_r;
    trn_nxt    = trn_r;

    // configuration writes
    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_METRES_PER_COUNT:    mpc_nxt = cfg_data;
        REG_TURN_PER_COUNT_DIFF: tpc_nxt = cfg_data;
      endcase
    end

    unique case (cmd.op)
      OP_NONE: ;
      // take the request, form S and T, seed the CORDIC
      OP_LOAD: begin
        prev_l_nxt = in_left_count;
        prev_r_nxt = in_right_count;
        first_nxt  = 1'b0;
        iv_nxt     = in_interval_us;
        mcs_nxt    = {{(PROD_W-SUM_W){s_sum[SUM_W-1]}}, s_sum};
        mct_nxt    = {{(PROD_W-SUM_W){t_dif[SUM_W-1]}}, t_dif};
        acc_p_nxt  = '0;
        acc_h_nxt  = '0;
        flip_nxt   = pose_h_r[HEAD_W-1] ^ pose_h_r[HEAD_W-2];
        cx_nxt     = CORD_GAIN;
        cy_nxt     = '0;
        cz_nxt     = signed'({{(CORD_W-HEAD_W){h_fold[HEAD_W-1]}}, h_fold});
      end
      // shift-add products S*mpc and T*tpc, CORDIC steps alongside
      OP_MUL1: begin
        if (mpc_r[cmd.idx[BIT_IDX_W-1:0]]) acc_p_nxt = acc_p_r + mcs_r;
        if (tpc_r[cmd.idx[BIT_IDX_W-1:0]]) acc_h_nxt = acc_h_r + mct_r;
        mcs_nxt = mcs_r << 1;
        mct_nxt = mct_r << 1;
        if (cmd.idx < CNT_W'(CORD_STEPS)) begin
          if (!cz_r[CORD_W-1]) begin
            cx_nxt = cx_r - ys;
            cy_nxt = cy_r + xs;
            cz_nxt = cz_r - at;
          end else begin
            cx_nxt = cx_r + ys;
            cy_nxt = cy_r - xs;
            cz_nxt = cz_r + at;
          end
        end
      end
      // travel, cosine and sine operands for the second pass
      OP_LD2: begin
        mcd_nxt    = {{(XY_W-TRAVEL_W){acc_p_r[PROD_W-1]}}, acc_p_r[PROD_W-1:TRAVEL_SH]};
        cm_nxt     = flip_r ? -cx_r : cx_r;
        sm_nxt     = flip_r ? -cy_r : cy_r;
        mcp_nxt    = {{(NUM_W-PROD_W){acc_p_r[PROD_W-1]}}, acc_p_r};
        mch_nxt    = {{(NUM_W-PROD_W){acc_h_r[PROD_W-1]}}, acc_h_r};
        acc_x_nxt  = '0;
        acc_y_nxt  = '0;
        acc_nl_nxt = '0;
        acc_nt_nxt = '0;
      end
      // signed travel*cos, travel*sin; P and H scaled to microseconds
      OP_MUL2: begin
        if (cm_r[0]) acc_x_nxt = last2 ? (acc_x_r - mcd_r) : (acc_x_r + mcd_r);
        if (sm_r[0]) acc_y_nxt = last2 ? (acc_y_r - mcd_r) : (acc_y_r + mcd_r);
        if (scale_bit(cmd.idx)) begin
          acc_nl_nxt = acc_nl_r + mcp_r;
          acc_nt_nxt = acc_nt_r + mch_r;
        end
        mcd_nxt = mcd_r << 1;
        cm_nxt  = cm_r >>> 1;
        sm_nxt  = sm_r >>> 1;
        mcp_nxt = mcp_r << 1;
        mch_nxt = mch_r << 1;
      end
      // magnitudes and divisors aligned to the top quotient bit
      OP_PREP: begin
        neg_l_nxt = acc_nl_r[NUM_W-1];
        neg_t_nxt = acc_nt_r[NUM_W-1];
        mag_l_nxt = acc_nl_r[NUM_W-1] ? (~acc_nl_r + 1'b1) : acc_nl_r;
        mag_t_nxt = acc_nt_r[NUM_W-1] ? (~acc_nt_r + 1'b1) : acc_nt_r;
        dsh_l_nxt = {iv_r, {(DEN_W-IV_W){1'b0}}};
        dsh_t_nxt = {1'b0, iv_r, {(DEN_W-IV_W-1){1'b0}}};
      end
      // quotient too large for the rate width saturates
      OP_CHK: begin
        ovf_l_nxt = (mag_l_r >= NUM_W'(dsh_l_r));
        ovf_t_nxt = (mag_t_r >= NUM_W'(dsh_t_r));
        rem_l_nxt = mag_l_r[DEN_W-1:0];
        rem_t_nxt = mag_t_r[DEN_W-1:0];
        q_l_nxt   = '0;
        q_t_nxt   = '0;
      end
      // restoring divide, one quotient bit per cycle
      OP_DIV: begin
        if (rem_l_r >= dsh_l_r) begin
          rem_l_nxt = rem_l_r - dsh_l_r;
          q_l_nxt   = {q_l_r[QUO_W-2:0], 1'b1};
        end else begin
          q_l_nxt   = {q_l_r[QUO_W-2:0], 1'b0};
        end
        if (rem_t_r >= dsh_t_r) begin
          rem_t_nxt = rem_t_r - dsh_t_r;
          q_t_nxt   = {q_t_r[QUO_W-2:0], 1'b1};
        end else begin
          q_t_nxt   = {q_t_r[QUO_W-2:0], 1'b0};
        end
        dsh_l_nxt = dsh_l_r >> 1;
        dsh_t_nxt = dsh_t_r >> 1;
      end
      // update the pose and load the result registers
      OP_COMMIT: begin
        pose_x_nxt = pos_sat(sum_x);
        pose_y_nxt = pos_sat(sum_y);
        pose_h_nxt = pose_h_r + acc_h_r[HEAD_W-1:0];
        lin_nxt    = rate_out(iv_r == '0, ovf_l_r, neg_l_r, q_l_r);
        trn_nxt    = rate_out(iv_r == '0, ovf_t_r, neg_t_r, q_t_r);
      end
      default: ;
    endcase
  end

  assign out_pos_x       = pose_x_r;
  assign out_pos_y       = pose_y_r;
  assign out_heading     = pose_h_r;
  assign out_linear_rate = lin_r;
  assign out_turn_rate   = trn_r;

endmodule

### src/diff_drive_odometry.sv
// Sequence: once a request is accepted, the multiply/CORDIC pass, a load, the second multiply,
//   setup, the divide and a commit run in order; out_valid rises after the commit.
// Flow: a new request is taken only after the previous one has been committed;
//   a finished result may wait while the next request is accepted and worked on.
// Reset: synchronous, active low; pose zero, registers at defaults, next
//   request taken as the count reference.
// ---------------------------------------------------------------------------
// diff_drive_odometry
// Differential-drive wheel odometry: pose integration and wheel rates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module diff_drive_odometry import ddo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [COUNT_W-1:0] in_left_count,
  input  logic signed [COUNT_W-1:0] in_right_count,
  input  logic [IV_W-1:0]          in_interval_us,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_pos_x,
  output logic signed [POS_W-1:0]  out_pos_y,
  output logic [HEAD_W-1:0]        out_heading,
  output logic signed [RATE_W-1:0] out_linear_rate,
  output logic signed [RATE_W-1:0] out_turn_rate
);

  cmd_t cmd;

  ddo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  ddo_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_left_count   (in_left_count),
    .in_right_count  (in_right_count),
    .in_interval_us  (in_interval_us),
    .cmd             (cmd),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_heading     (out_heading),
    .out_linear_rate (out_linear_rate),
    .out_turn_rate   (out_turn_rate)
  );

  // Checks
  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `ASSERT_NEXT(a_commit_shows_result, cmd.op == OP_COMMIT, out_valid, "commit lost result")
  `ASSERT_ALWAYS(a_idle_ops, !in_ready || cmd.op == OP_NONE || cmd.op == OP_LOAD, "op when idle")

endmodule
